// ===== rtl/core/lu_decomposition_doolittle_macros.svh =====
// assertion macros shared by the lu factorization rtl
// depends on i_clk and i_rst_n being visible where a macro is used
`ifndef LU_DECOMPOSITION_DOOLITTLE_MACROS_SVH
`define LU_DECOMPOSITION_DOOLITTLE_MACROS_SVH

// expression must never hold outside reset
`define LUDD_ASSERT_NEVER(lbl, expr) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(expr)) \
        else $error("ludd assertion failed");

// antecedent in this cycle implies consequent in the next
`define LUDD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ludd assertion failed");

// antecedent implies consequent in the same cycle
`define LUDD_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ludd assertion failed");

`endif

// ===== rtl/core/ludd_pkg.sv =====
// types and constants of the lu factorization block
// no dependencies
package ludd_pkg;

    localparam int DIV_STEPS = 48;   // quotient bits of (num << 16) / den
    localparam int REM_W     = 33;
    localparam int RQ_W      = REM_W + DIV_STEPS;

    // one stage of the divider chain
    typedef struct packed {
        logic            valid;
        logic            neg;
        logic [31:0]     den;
        logic [RQ_W-1:0] rq;   // remainder over partial dividend / quotient
    } t_div_stage;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_RD_INIT,
        ST_WAIT_INIT,
        ST_RD_OP,
        ST_MUL,
        ST_SHIFT,
        ST_ACC,
        ST_WRITE,
        ST_DIV,
        ST_DIV_WAIT,
        ST_EMIT_RD,
        ST_EMIT
    } t_state;

endpackage

// ===== rtl/core/ludd_div_cell.sv =====
// one restoring division step, registered
// depends on ludd_pkg
module ludd_div_cell import ludd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_div_stage i_stage,
    output t_div_stage o_stage
);

    t_div_stage        r_stage;
    logic [REM_W-1:0]  sh;
    logic [DIV_STEPS-1:0] dvd;
    logic [REM_W-1:0]  diff;

    always_comb begin
        sh   = {i_stage.rq[RQ_W-2:DIV_STEPS], i_stage.rq[DIV_STEPS-1]};
        dvd  = {i_stage.rq[DIV_STEPS-2:0], 1'b0};
        diff = sh - {1'b0, i_stage.den};
        if (sh >= {1'b0, i_stage.den}) begin
            sh     = diff;
            dvd[0] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage.valid <= 1'b0;
        end else begin
            r_stage.valid <= i_stage.valid;
        end
        r_stage.neg <= i_stage.neg;
        r_stage.den <= i_stage.den;
        r_stage.rq  <= {sh, dvd};
    end

    assign o_stage = r_stage;

endmodule

// ===== rtl/core/ludd_div_chain.sv =====
// row of division cells, one quotient bit per cell
// depends on ludd_pkg and ludd_div_cell
module ludd_div_chain import ludd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_div_stage i_stage,
    output t_div_stage o_stage
);

    t_div_stage link [DIV_STEPS+1];

    assign link[0] = i_stage;

    for (genvar g = 0; g < DIV_STEPS; g++) begin : g_cell
        ludd_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_stage (link[g]),
            .o_stage (link[g+1])
        );
    end

    assign o_stage = link[DIV_STEPS];

endmodule

// ===== rtl/core/lu_decomposition_doolittle.sv =====
// doolittle lu factorization, no pivoting, signed q16.16
// load: one element per cycle while in the load state; the last element starts the factorization
// factor: per entry a read, then one multiply-accumulate per earlier term on the shared
// multiplier; an l entry with a nonzero pivot then passes through the 48-cell divider chain
// emit: each result is read from store read port 0, then offered; input is held off
// reset: synchronous active low, matrix_size back to 8, counters and flags cleared
module lu_decomposition_doolittle
    import ludd_pkg::*;
#(
    parameter int MAX_SIZE = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input request stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] element_value
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [2:0] row_index, [5:3] column_index,
                                        // [37:6] factor_value, [39:38] zero pad
    output logic [1:0]  m_axis_tuser,   // [0] zero_pivot, [1] saturated
    output logic        m_axis_tlast    // last_element
);

    `include "lu_decomposition_doolittle_macros.svh"

    localparam int DEPTH = MAX_SIZE * MAX_SIZE;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // configuration
    logic [3:0] r_size;
    logic       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr == 3'd0);
    assign prdata = (paddr == 3'd0) ? {28'd0, r_size} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= 4'd8;
        end else if (cfg_wr) begin
            r_size <= pwdata[3:0];
        end
    end

    // size in use: zero acts as one, oversize clamps to the built maximum
    logic [3:0] n_act;
    logic [6:0] total_act;
    assign n_act = (r_size == 4'd0) ? 4'd1 :
                   (r_size > 4'(MAX_SIZE)) ? 4'(MAX_SIZE) : r_size;
    assign total_act = 7'(n_act * n_act);

    function automatic logic [AW-1:0] f_addr(logic [2:0] row, logic [2:0] col,
                                             logic [3:0] n);
        logic [6:0] a;
        a = 7'(row * n) + 7'(col);
        return a[AW-1:0];
    endfunction

    // control and datapath registers
    t_state             r_state, n_state;
    logic [6:0]         r_cnt;
    logic [6:0]         r_total;
    logic [3:0]         r_n;
    logic [2:0]         r_k, r_row, r_col, r_s;
    logic               r_isl;
    logic               r_zero, r_sat;
    logic signed [31:0] r_acc, r_p, r_piv;
    logic signed [63:0] r_prod;
    logic [6:0]         r_eidx;
    logic [2:0]         r_erow, r_ecol;

    // store: one write port, two registered read ports
    logic signed [31:0] r_mem [DEPTH];
    logic signed [31:0] r_rd0, r_rd1;
    logic [AW-1:0]      rd_addr0, rd_addr1, wr_addr;
    logic               wr_en;
    logic signed [31:0] wr_data;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd0 <= r_mem[rd_addr0];
        r_rd1 <= r_mem[rd_addr1];
    end

    // handshakes
    logic in_req, out_req;
    logic [6:0] cnt_inc;
    logic start;
    assign s_axis_tready = (r_state == ST_LOAD);
    assign in_req  = s_axis_tvalid && s_axis_tready;
    assign out_req = m_axis_tvalid && m_axis_tready;
    assign cnt_inc = r_cnt + 7'd1;           // wraps like the 7-bit load count
    assign start   = in_req && (cnt_inc >= total_act);

    // walk of the factorization: u row k, then l column k
    logic u_last, l_last, k_last, adv_done;
    logic [2:0] adv_k, adv_row, adv_col;
    logic adv_isl;
    always_comb begin
        u_last   = ({1'b0, r_col} == r_n - 4'd1);
        l_last   = ({1'b0, r_row} == r_n - 4'd1);
        k_last   = ({1'b0, r_k} == r_n - 4'd1);
        adv_done = 1'b0;
        adv_k    = r_k;
        adv_row  = r_row;
        adv_col  = r_col;
        adv_isl  = r_isl;
        if (!r_isl) begin
            if (!u_last) begin
                adv_col = r_col + 3'd1;
            end else if (k_last) begin
                adv_done = 1'b1;
            end else begin
                adv_isl = 1'b1;
                adv_row = r_k + 3'd1;
                adv_col = r_k;
            end
        end else begin
            if (!l_last) begin
                adv_row = r_row + 3'd1;
            end else begin
                adv_k   = r_k + 3'd1;
                adv_isl = 1'b0;
                adv_row = r_k + 3'd1;
                adv_col = r_k + 3'd1;
            end
        end
    end

    // product: floor shift by 16, then clip
    logic signed [63:0] prod_sh;
    logic               prod_hi, prod_lo;
    logic signed [32:0] diff;
    logic               diff_hi, diff_lo;
    assign prod_sh = r_prod >>> 16;
    assign prod_hi = prod_sh > 64'sd2147483647;
    assign prod_lo = prod_sh < -64'sd2147483648;
    assign diff    = {r_acc[31], r_acc} - {r_p[31], r_p};
    assign diff_hi = diff > 33'sd2147483647;
    assign diff_lo = diff < -33'sd2147483648;

    // divider chain: magnitudes in, sign and clip after
    t_div_stage div_in, div_out;
    logic [31:0] num_mag, den_mag;
    assign num_mag = r_acc[31] ? 32'(-r_acc) : 32'(r_acc);
    assign den_mag = r_piv[31] ? 32'(-r_piv) : 32'(r_piv);
    always_comb begin
        div_in.valid = (r_state == ST_DIV);
        div_in.neg   = r_acc[31] ^ r_piv[31];
        div_in.den   = den_mag;
        div_in.rq    = {{REM_W{1'b0}}, num_mag, 16'd0};
    end

    ludd_div_chain u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stage (div_in),
        .o_stage (div_out)
    );

    logic [DIV_STEPS-1:0] quo;
    logic                 quo_sat;
    logic signed [31:0]   quo_val;
    always_comb begin
        quo     = div_out.rq[DIV_STEPS-1:0];
        quo_sat = div_out.neg ? (quo > 48'h0000_8000_0000) : (quo > 48'h0000_7fff_ffff);
        if (quo_sat) begin
            quo_val = div_out.neg ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end else begin
            quo_val = div_out.neg ? 32'(-quo[31:0]) : quo[31:0];
        end
    end

    // next state and store port control
    always_comb begin
        n_state  = r_state;
        rd_addr0 = f_addr(r_row, r_col, r_n);
        rd_addr1 = f_addr(r_s, r_col, r_n);
        wr_en    = 1'b0;
        wr_addr  = f_addr(r_row, r_col, r_n);
        wr_data  = r_acc;
        case (r_state)
            ST_LOAD: begin
                wr_en   = in_req && (r_cnt < 7'(DEPTH));
                wr_addr = r_cnt[AW-1:0];
                wr_data = s_axis_tdata;
                if (start) n_state = ST_RD_INIT;
            end
            ST_RD_INIT:   n_state = ST_WAIT_INIT;
            ST_WAIT_INIT: n_state = (r_k == 3'd0) ? ST_WRITE : ST_RD_OP;
            ST_RD_OP: begin
                rd_addr0 = f_addr(r_row, r_s, r_n);
                n_state  = ST_MUL;
            end
            ST_MUL:   n_state = ST_SHIFT;
            ST_SHIFT: n_state = ST_ACC;
            ST_ACC:   n_state = ((r_s + 3'd1) == r_k) ? ST_WRITE : ST_RD_OP;
            ST_WRITE: begin
                if (r_isl && (r_piv != 32'sd0)) begin
                    n_state = ST_DIV;
                end else begin
                    wr_en   = 1'b1;
                    wr_data = r_isl ? 32'sd0 : r_acc;   // zero pivot forces l to 0
                    n_state = adv_done ? ST_EMIT_RD : ST_RD_INIT;
                end
            end
            ST_DIV: n_state = ST_DIV_WAIT;
            ST_DIV_WAIT: begin
                if (div_out.valid) begin
                    wr_en   = 1'b1;
                    wr_data = quo_val;
                    n_state = adv_done ? ST_EMIT_RD : ST_RD_INIT;
                end
            end
            ST_EMIT_RD: begin
                rd_addr0 = r_eidx[AW-1:0];
                n_state  = ST_EMIT;
            end
            ST_EMIT: begin
                rd_addr0 = r_eidx[AW-1:0];
                if (out_req) n_state = m_axis_tlast ? ST_LOAD : ST_EMIT_RD;
            end
            default: n_state = ST_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_cnt   <= 7'd0;
            r_zero  <= 1'b0;
            r_sat   <= 1'b0;
        end else begin
            r_state <= n_state;
            case (r_state)
                ST_LOAD: begin
                    if (in_req) r_cnt <= start ? 7'd0 : cnt_inc;
                end
                ST_SHIFT: begin
                    if (prod_hi || prod_lo) r_sat <= 1'b1;
                end
                ST_ACC: begin
                    if (diff_hi || diff_lo) r_sat <= 1'b1;
                end
                ST_WRITE: begin
                    if (!r_isl && (r_col == r_k) && (r_acc == 32'sd0)) r_zero <= 1'b1;
                end
                ST_DIV_WAIT: begin
                    if (div_out.valid && quo_sat) r_sat <= 1'b1;
                end
                ST_EMIT: begin
                    if (out_req && m_axis_tlast) begin
                        r_zero <= 1'b0;
                        r_sat  <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_LOAD: begin
                r_n     <= n_act;
                r_total <= total_act;
                r_k     <= 3'd0;
                r_row   <= 3'd0;
                r_col   <= 3'd0;
                r_isl   <= 1'b0;
                r_eidx  <= 7'd0;
                r_erow  <= 3'd0;
                r_ecol  <= 3'd0;
            end
            ST_WAIT_INIT: begin
                r_acc <= r_rd0;
                r_s   <= 3'd0;
            end
            ST_MUL:   r_prod <= r_rd0 * r_rd1;
            ST_SHIFT: r_p <= prod_hi ? 32'sh7fff_ffff : prod_lo ? 32'sh8000_0000 :
                             prod_sh[31:0];
            ST_ACC: begin
                r_acc <= diff_hi ? 32'sh7fff_ffff : diff_lo ? 32'sh8000_0000 : diff[31:0];
                r_s   <= r_s + 3'd1;
            end
            ST_WRITE: begin
                if (!r_isl && (r_col == r_k)) r_piv <= r_acc;
                if (!(r_isl && (r_piv != 32'sd0))) begin
                    r_k   <= adv_k;
                    r_row <= adv_row;
                    r_col <= adv_col;
                    r_isl <= adv_isl;
                end
            end
            ST_DIV_WAIT: begin
                if (div_out.valid) begin
                    r_k   <= adv_k;
                    r_row <= adv_row;
                    r_col <= adv_col;
                    r_isl <= adv_isl;
                end
            end
            ST_EMIT: begin
                if (out_req) begin
                    r_eidx <= r_eidx + 7'd1;
                    if ({1'b0, r_ecol} == r_n - 4'd1) begin
                        r_ecol <= 3'd0;
                        r_erow <= r_erow + 3'd1;
                    end else begin
                        r_ecol <= r_ecol + 3'd1;
                    end
                end
            end
            default: ;
        endcase
    end

    // result stream, read data of the store drives the value
    assign m_axis_tvalid = (r_state == ST_EMIT);
    assign m_axis_tdata  = {2'b00, r_rd0, r_ecol, r_erow};
    assign m_axis_tuser  = {r_sat, r_zero};
    assign m_axis_tlast  = (r_eidx == r_total - 7'd1);

    // never take a new element while results are still offered
    `LUDD_ASSERT_NEVER(a_no_overlap, s_axis_tready && m_axis_tvalid)
    // the divider only answers while the sequencer waits for it
    `LUDD_ASSERT_SAME(a_div_in_wait, div_out.valid, r_state == ST_DIV_WAIT)
    // after the final result the block is back to loading from an empty count
    `LUDD_ASSERT_NEXT(a_last_clears, out_req && m_axis_tlast, (r_state == ST_LOAD) && (r_cnt == 7'd0) && !r_zero && !r_sat)

endmodule

// ===== tb/testbench.sv =====
// self-checking testbench of the lu factorization block
// depends on ludd_pkg and lu_decomposition_doolittle; no files or arguments
`timescale 1ns / 100ps

module testbench;
    import ludd_pkg::*;

    localparam int MAX_N        = 8;
    localparam int CYCLE_LIMIT  = 3000000;
    localparam logic [2:0] ADDR_MATRIX_SIZE = 3'd0;

    typedef struct packed {
        logic [2:0]  row;
        logic [2:0]  col;
        logic [31:0] value;
        logic        zero_piv;
        logic        sat;
        logic        last;
    } t_factor;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;    // [31:0] element_value
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;    // [2:0] row, [5:3] column, [37:6] factor, [39:38] pad
    logic [1:0]  m_axis_tuser;    // [0] zero_pivot, [1] saturated
    logic        m_axis_tlast;

    // predictor state
    logic [3:0]         size_reg;
    logic signed [31:0] mat [0:63];
    int                 loaded;
    bit                 piv_zero_flag;
    bit                 sat_flag;

    t_factor expected_q[$];
    int      errors;
    int      cycles;
    int      requests_sent;
    int      factors_seen;
    int      matrices_done;
    bit      quiet_out;   // no stall on the result side near the end

    lu_decomposition_doolittle u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // saturate a wide value to q16.16, remembering any clip
    function automatic logic signed [31:0] clip_q(input logic signed [65:0] v);
        if (v > 66'sd2147483647) begin
            sat_flag = 1'b1;
            return 32'sh7fffffff;
        end
        if (v < -66'sd2147483648) begin
            sat_flag = 1'b1;
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    // arithmetic shift is floor division by 65536
    function automatic logic signed [31:0] q_mul(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
        logic signed [65:0] p;
        p = 66'(a) * 66'(b);
        return clip_q(p >>> 16);
    endfunction

    // truncating division of (num << 16) by the pivot
    function automatic logic signed [31:0] q_div(input logic signed [31:0] num,
                                                 input logic signed [31:0] den);
        logic signed [65:0] n66;
        n66 = 66'(num) * 66'sd65536;
        return clip_q(n66 / 66'(den));
    endfunction

    function automatic logic signed [31:0] q_sub(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
        return clip_q(66'(a) - 66'(b));
    endfunction

    function automatic int eff_size();
        if (size_reg == 0) return 1;
        if (size_reg > MAX_N) return MAX_N;
        return size_reg;
    endfunction

    // in-place doolittle factorization of the first n*n stored elements
    task automatic factor_matrix(input int n);
        logic signed [31:0] acc;
        logic signed [31:0] piv;
        for (int k = 0; k < n; k++) begin
            for (int j = k; j < n; j++) begin
                acc = mat[k*n+j];
                for (int s = 0; s < k; s++)
                    acc = q_sub(acc, q_mul(mat[k*n+s], mat[s*n+j]));
                mat[k*n+j] = acc;
            end
            piv = mat[k*n+k];
            if (piv == 0) piv_zero_flag = 1'b1;
            for (int i = k + 1; i < n; i++) begin
                acc = mat[i*n+k];
                for (int s = 0; s < k; s++)
                    acc = q_sub(acc, q_mul(mat[i*n+s], mat[s*n+k]));
                mat[i*n+k] = (piv == 0) ? 32'sd0 : q_div(acc, piv);
            end
        end
    endtask

    // account one accepted element request, queueing the packed factors it completes
    task automatic predict_element(input logic [31:0] val);
        int n;
        t_factor f;
        n = eff_size();
        if (loaded < 64) mat[loaded] = val;
        loaded = (loaded + 1) & 127;
        if (loaded < n * n) return;
        factor_matrix(n);
        for (int r = 0; r < n; r++)
            for (int c = 0; c < n; c++) begin
                f.row      = r[2:0];
                f.col      = c[2:0];
                f.value    = mat[r*n+c];
                f.zero_piv = piv_zero_flag;
                f.sat      = sat_flag;
                f.last     = (r * n + c + 1 == n * n);
                expected_q.push_back(f);
            end
        loaded        = 0;
        piv_zero_flag = 1'b0;
        sat_flag      = 1'b0;
        matrices_done++;
    endtask

    // cycle counter and overall timeout
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout at %0t", $time);
            $display("Mismatches found");
            $finish;
        end
    end

    // result side: random stall bursts, compare against the oldest expectation
    initial begin
        int stall;
        t_factor exp_f;
        m_axis_tready = 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            stall = quiet_out ? 0 : (($urandom_range(0, 3) == 0) ? $urandom_range(1, 5) : 0);
            if (stall != 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!(m_axis_tvalid && m_axis_tready)) @(posedge i_clk);
            factors_seen++;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result, actual data %h user %b last %b",
                         $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
                errors++;
            end else begin
                exp_f = expected_q.pop_front();
                if (m_axis_tdata[2:0] !== exp_f.row) begin
                    $display("%0t: row expected %0d actual %0d",
                             $time, exp_f.row, m_axis_tdata[2:0]);
                    errors++;
                end
                if (m_axis_tdata[5:3] !== exp_f.col) begin
                    $display("%0t: column expected %0d actual %0d",
                             $time, exp_f.col, m_axis_tdata[5:3]);
                    errors++;
                end
                if (m_axis_tdata[37:6] !== exp_f.value) begin
                    $display("%0t: factor (%0d,%0d) expected %h actual %h", $time,
                             exp_f.row, exp_f.col, exp_f.value, m_axis_tdata[37:6]);
                    errors++;
                end
                if (m_axis_tuser[0] !== exp_f.zero_piv) begin
                    $display("%0t: zero_pivot expected %b actual %b",
                             $time, exp_f.zero_piv, m_axis_tuser[0]);
                    errors++;
                end
                if (m_axis_tuser[1] !== exp_f.sat) begin
                    $display("%0t: saturated expected %b actual %b",
                             $time, exp_f.sat, m_axis_tuser[1]);
                    errors++;
                end
                if (m_axis_tlast !== exp_f.last) begin
                    $display("%0t: last expected %b actual %b",
                             $time, exp_f.last, m_axis_tlast);
                    errors++;
                end
            end
        end
    end

    // one element request, with an optional idle burst before it
    task automatic send_element(input logic [31:0] val, input bit gaps);
        int idle;
        idle = (gaps && $urandom_range(0, 3) == 0) ? $urandom_range(1, 5) : 0;
        if (idle != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (idle) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= val;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predict_element(val);
        requests_sent++;
    endtask

    // wait for every expected factor plus time for the block to settle
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    // apb write: setup then access, register taken when penable and pready are high
    task automatic write_size(input logic [3:0] n);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_MATRIX_SIZE;
        pwdata  <= {28'd0, n};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        size_reg = n;
    endtask

    // a random element: mostly modest values, sometimes extremes or zero
    function automatic logic [31:0] rand_element();
        case ($urandom_range(0, 9))
            0:       return $urandom();
            1:       return 32'd0;
            2:       return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
            default: return 32'($signed($urandom_range(0, 32'h00080000)) - 32'sh00040000);
        endcase
    endfunction

    // directed table: size, element, and whether a known expected value is given with it
    typedef struct {
        logic [3:0]  size;
        logic [31:0] elem;
        bit          known;
        logic [31:0] exp_value;
    } t_row;

    t_row plan [$];
    t_factor got;

    initial begin
        int n;
        int target;
        logic [3:0] sizes [6];
        i_rst_n       = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        errors = 0; cycles = 0; requests_sent = 0; factors_seen = 0;
        matrices_done = 0; quiet_out = 1'b0;
        size_reg = 4'd8; loaded = 0; piv_zero_flag = 0; sat_flag = 0;
        for (int i = 0; i < 64; i++) mat[i] = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part: size 1 extremes (result equals the element),
        // size 0 acting as 1, zero pivot and saturating 2x2 cases, and a plain 3x3 case
        plan = '{
            '{4'd1, 32'h7fffffff, 1, 32'h7fffffff},
            '{4'd1, 32'h80000000, 1, 32'h80000000},
            '{4'd0, 32'h00000000, 1, 32'h00000000},
            '{4'd0, 32'hffffffff, 1, 32'hffffffff},
            // 2x2 with zero pivot: l entry forced to 0
            '{4'd2, 32'h00000000, 0, 0}, '{4'd2, 32'h00010000, 0, 0},
            '{4'd2, 32'h00030000, 0, 0}, '{4'd2, 32'h00020000, 0, 0},
            // 2x2 where the quotient and the product clip
            '{4'd2, 32'h00000001, 0, 0}, '{4'd2, 32'h7fffffff, 0, 0},
            '{4'd2, 32'h7fffffff, 0, 0}, '{4'd2, 32'h80000000, 0, 0},
            // 3x3 plain
            '{4'd3, 32'h00020000, 0, 0}, '{4'd3, 32'h00010000, 0, 0},
            '{4'd3, 32'hffff0000, 0, 0}, '{4'd3, 32'h00040000, 0, 0},
            '{4'd3, 32'h00058000, 0, 0}, '{4'd3, 32'h00008000, 0, 0},
            '{4'd3, 32'hfffe0000, 0, 0}, '{4'd3, 32'h00010000, 0, 0},
            '{4'd3, 32'h00070000, 0, 0}
        };
        for (int i = 0; i < plan.size(); i++) begin
            if (plan[i].size != size_reg) begin
                drain();
                write_size(plan[i].size);
            end
            send_element(plan[i].elem, 1'b0);
            if (plan[i].known) begin
                // check the typed value against the predictor too
                got = expected_q[expected_q.size() - 1];
                if (got.value !== plan[i].exp_value) begin
                    $display("%0t: table row %0d expected %h predicted %h",
                             $time, i, plan[i].exp_value, got.value);
                    errors++;
                end
            end
        end
        drain();

        // random part: phases over sizes, extremes and out-of-range among them
        sizes = '{4'd8, 4'd2, 4'd4, 4'd15, 4'd3, 4'd5};
        target = 460;
        for (int ph = 0; requests_sent < target; ph++) begin
            n = (ph < 6) ? sizes[ph] : $urandom_range(0, 15);
            write_size(n[3:0]);
            if (ph == 7) quiet_out = 1'b0;
            for (int m = 0; m < 3 && requests_sent < target; m++) begin
                if (requests_sent > target - 60) quiet_out = 1'b1;
                for (int e = 0; e < eff_size() * eff_size(); e++)
                    send_element(rand_element(), requests_sent < target - 60);
            end
            // finish a partial matrix so every phase ends idle
            while (loaded != 0) send_element(rand_element(), 1'b0);
            drain();
        end

        $display("covered %0d element requests, %0d matrices, %0d factor results",
                 requests_sent, matrices_done, factors_seen);
        if (errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
